>>> rtl/yuv420_to_rgb_rotate90_defines.svh
// Assertion macros used by the checker file.
`ifndef YUV420_TO_RGB_ROTATE90_DEFINES_SVH
`define YUV420_TO_RGB_ROTATE90_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define Y2R_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("y2r check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define Y2R_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("y2r check failed");

`endif

>>> rtl/y2r_pkg.sv
`default_nettype none

package y2r_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 27;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] WIDTH_MIN  = DIM_W'(2);
  localparam logic [DIM_W-1:0] HEIGHT_MIN = DIM_W'(1);
  localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIM);

  localparam logic signed [SUM_W-1:0] COEF_RV = SUM_W'(91881);
  localparam logic signed [SUM_W-1:0] COEF_GU = SUM_W'(22554);
  localparam logic signed [SUM_W-1:0] COEF_GV = SUM_W'(46802);
  localparam logic signed [SUM_W-1:0] COEF_BU = SUM_W'(116130);

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] col_rev;
    logic [CNT_W-1:0] row;
    logic [DIM_W-1:0] height;
    logic             last;
  } pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lo);
    logic [DIM_W-1:0] res;
    if (v < lo) begin
      res = lo;
    end else if (v > DIM_MAX) begin
      res = DIM_MAX;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] sat_byte(input logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:16+PIX_W]) begin
      res = '1;
    end else begin
      res = s[16+PIX_W-1:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/y2r_pos.sv
`default_nettype none

module y2r_pos import y2r_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire cfg_idx_t         cfg_idx,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             adv,
  output pos_t                  pos
);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] w_m1, h_m1, col_eff, row_eff;
  logic             last_col, last_row;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_WIDTH:  width_nxt  = clamp_dim(cfg_wdata, WIDTH_MIN);
        CFG_HEIGHT: height_nxt = clamp_dim(cfg_wdata, HEIGHT_MIN);
        default:    width_nxt  = width_r;
      endcase
    end
  end

  // Counters left past the frame edges by a register write saturate.
  assign w_m1     = CNT_W'(width_r - DIM_W'(1));
  assign h_m1     = CNT_W'(height_r - DIM_W'(1));
  assign col_eff  = ({1'b0, col_r} < width_r) ? col_r : w_m1;
  assign row_eff  = ({1'b0, row_r} < height_r) ? row_r : h_m1;
  assign last_col = (col_eff == w_m1);
  assign last_row = (row_eff == h_m1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_eff + CNT_W'(1);
      end else begin
        col_nxt = col_eff + CNT_W'(1);
        row_nxt = row_eff;
      end
    end
  end

  assign pos.col_rev = w_m1 - col_eff;
  assign pos.row     = row_eff;
  assign pos.height  = height_r;
  assign pos.last    = last_col & last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/y2r_color.sv
`default_nettype none

module y2r_color import y2r_pkg::*; (
  input  wire logic [PIX_W-1:0] luma,
  input  wire logic [PIX_W-1:0] cb,
  input  wire logic [PIX_W-1:0] cr,
  output logic      [PIX_W-1:0] red,
  output logic      [PIX_W-1:0] green,
  output logic      [PIX_W-1:0] blue
);

  logic signed [SUM_W-1:0] ys, du, dv;
  logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

  // Flipping the top bit of an offset-128 byte gives its signed value.
  assign ys = $signed({{(SUM_W-PIX_W-16){1'b0}}, luma, 16'b0});
  assign du = $signed({{(SUM_W-PIX_W+1){~cb[PIX_W-1]}}, cb[PIX_W-2:0]});
  assign dv = $signed({{(SUM_W-PIX_W+1){~cr[PIX_W-1]}}, cr[PIX_W-2:0]});

  assign sum_r = ys + COEF_RV * dv;
  assign sum_g = ys - COEF_GU * du - COEF_GV * dv;
  assign sum_b = ys + COEF_BU * du;

  assign red   = sat_byte(sum_r);
  assign green = sat_byte(sum_g);
  assign blue  = sat_byte(sum_b);

endmodule

`default_nettype wire

>>> rtl/yuv420_to_rgb_rotate90.sv
// YUV 4:2:0 to RGBA converter with output addressing for a 90 degree rotation.
// The input channel takes one pixel per beat in raster order: its luma byte and
// the chroma pair of its 2x2 block. The output channel gives one beat per pixel
// with red, green, blue, a constant alpha of 255, the pixel's index in the
// rotated image and a flag on the last pixel of the frame.
// The configuration port sets the frame width and height; values out of range
// are clamped when written. Write it only while no pixel is in flight.
// The data path has two register stages: the input register holds the pixel and
// its position, the output register holds the finished result. An accepted beat
// passes through the input register and then the output register, and one pixel
// is accepted per cycle for as long as the receiver takes results.
// When the receiver stalls, the output register holds its beat and the input
// register fills; in_ready drops only when both stages are full, and it comes
// back combinationally with out_ready.
// Reset empties both stages, clears the column and row counters and sets the
// frame to 640 by 480.
`default_nettype none

module yuv420_to_rgb_rotate90 import y2r_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_idx,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_luma,
  input  wire logic [PIX_W-1:0] in_chroma_blue,
  input  wire logic [PIX_W-1:0] in_chroma_red,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [PIX_W-1:0] out_red,
  output logic      [PIX_W-1:0] out_green,
  output logic      [PIX_W-1:0] out_blue,
  output logic      [PIX_W-1:0] out_alpha,
  output logic      [IDX_W-1:0] out_dest_index,
  output logic                  out_frame_end
);

  localparam int unsigned PROD_W = DIM_W + CNT_W;

  logic             in_acc, s2_adv;
  pos_t             pos;
  logic             s1_vld_r, s1_vld_nxt;
  logic [PIX_W-1:0] s1_y_r, s1_u_r, s1_v_r;
  pos_t             s1_pos_r;
  logic             out_vld_r, out_vld_nxt;
  logic [PIX_W-1:0] red_c, green_c, blue_c;
  logic [PROD_W-1:0] dest_c;
  logic [PIX_W-1:0] red_r, green_r, blue_r;
  logic [IDX_W-1:0] dest_r;
  logic             end_r;

  assign s2_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s2_adv;
  assign in_acc   = in_valid && in_ready;

  y2r_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx_t'(cfg_idx)),
    .cfg_wdata (cfg_wdata),
    .adv       (in_acc),
    .pos       (pos)
  );

  y2r_color u_color (
    .luma  (s1_y_r),
    .cb    (s1_u_r),
    .cr    (s1_v_r),
    .red   (red_c),
    .green (green_c),
    .blue  (blue_c)
  );

  assign dest_c = s1_pos_r.height * s1_pos_r.col_rev + PROD_W'(s1_pos_r.row);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s2_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_y_r   <= in_luma;
      s1_u_r   <= in_chroma_blue;
      s1_v_r   <= in_chroma_red;
      s1_pos_r <= pos;
    end
    if (s2_adv) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
      dest_r  <= dest_c[IDX_W-1:0];
      end_r   <= s1_pos_r.last;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_alpha      = ALPHA_OPAQUE;
  assign out_dest_index = dest_r;
  assign out_frame_end  = end_r;

endmodule

`default_nettype wire

>>> rtl/y2r_check.sv
`default_nettype none
`include "yuv420_to_rgb_rotate90_defines.svh"

module y2r_check import y2r_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             cfg_we,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] out_red,
  input wire logic [PIX_W-1:0] out_green,
  input wire logic [PIX_W-1:0] out_blue,
  input wire logic [PIX_W-1:0] out_alpha,
  input wire logic [IDX_W-1:0] out_dest_index,
  input wire logic             out_frame_end
);

  // A stalled result beat stays and keeps its payload.
  `Y2R_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_dest_index) && $stable(out_frame_end))

  // With the output stage empty the block can always take a pixel.
  `Y2R_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // Alpha is opaque on every result beat.
  `Y2R_ASSERT_NOW(a_alpha_opaque, out_valid, out_alpha == ALPHA_OPAQUE)

  // A taken result with no new pixel coming in leaves the block ready to take one.
  `Y2R_ASSERT_NEXT(a_drain, out_valid && out_ready && in_ready && !in_valid && !cfg_we, in_ready)

endmodule

bind yuv420_to_rgb_rotate90 y2r_check u_y2r_check (.*);

`default_nettype wire
